### rtl/core/dcr_pkg.sv
package dcr_pkg;

   localparam int VEL_W           = 32;
   localparam int MASS_W          = 32;
   localparam int ELAS_W          = 16;
   localparam int FLAG_W          = 3;
   localparam int MAG_W           = 32;
   localparam int NRM_Q_W         = 31;
   localparam int NRM_FRAC        = 30;
   localparam int RATIO_W         = 30;
   localparam int RATIO_FRAC      = 28;
   localparam int ELAS_FRAC       = 8;
   localparam int MSUM_W          = MASS_W + 1;
   localparam int PROJ_W          = 34;
   localparam int CHG_W           = 42;
   localparam int SQRT_STAGES     = MAG_W;
   localparam int NRM_DIV_STAGES  = NRM_Q_W;
   localparam int MASS_DIV_STAGES = RATIO_W;
   localparam int FRONT_LAT       = SQRT_STAGES + NRM_DIV_STAGES;

   localparam int FLAG_FIRST_MOV  = 0;
   localparam int FLAG_SECOND_MOV = 1;
   localparam int FLAG_SECOND_HIT = 2;

   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC;

   typedef struct packed {
      logic signed [VEL_W-1:0] v1x;
      logic signed [VEL_W-1:0] v1y;
      logic signed [VEL_W-1:0] v2x;
      logic signed [VEL_W-1:0] v2y;
      logic [ELAS_W-1:0]       e1;
      logic [ELAS_W-1:0]       e2;
      logic                    first_mov;
      logic                    second_mov;
      logic                    neg_x;
      logic                    neg_y;
      logic                    go;
      logic                    msum_zero;
   } side_type;

   typedef struct packed {
      logic [RATIO_W-1:0] r1;
      logic [RATIO_W-1:0] r2;
   } ratio_type;

   typedef struct packed {
      logic               vld;
      logic [NRM_Q_W-1:0] qx;
      logic [NRM_Q_W-1:0] qy;
      ratio_type          ratio;
      side_type           side;
   } resp_in_type;

   typedef struct packed {
      logic                       vld;
      logic                       hit;
      logic [3:0][VEL_W-1:0]      vel;
   } resp_out_type;

endpackage

### rtl/core/dcr_delay.sv
module dcr_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      line_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

### rtl/core/dcr_isqrt.sv
module dcr_isqrt
   import dcr_pkg::*;
(
   input  logic               clock,
   input  logic [2*MAG_W-1:0] radicand,
   output logic [MAG_W-1:0]   root
);

   localparam int REM_W = MAG_W + 2;

   logic [2*MAG_W-1:0] rad_ff    [SQRT_STAGES];
   logic [REM_W-1:0]   rem_ff    [SQRT_STAGES];
   logic [MAG_W-1:0]   root_ff   [SQRT_STAGES];
   logic [2*MAG_W-1:0] rad_in    [SQRT_STAGES];
   logic [REM_W-1:0]   rem_in    [SQRT_STAGES];
   logic [MAG_W-1:0]   root_in   [SQRT_STAGES];
   logic [2*MAG_W-1:0] rad_prev  [SQRT_STAGES];
   logic [REM_W-1:0]   rem_prev  [SQRT_STAGES];
   logic [MAG_W-1:0]   root_prev [SQRT_STAGES];
   logic [REM_W-1:0]   rem_sh    [SQRT_STAGES];
   logic [REM_W-1:0]   trial     [SQRT_STAGES];

   always_comb begin
      rad_prev[0]  = radicand;
      rem_prev[0]  = '0;
      root_prev[0] = '0;
      for (int i = 1; i < SQRT_STAGES; i++) begin
         rad_prev[i]  = rad_ff[i-1];
         rem_prev[i]  = rem_ff[i-1];
         root_prev[i] = root_ff[i-1];
      end
      for (int i = 0; i < SQRT_STAGES; i++) begin
         rem_sh[i] = {rem_prev[i][REM_W-3:0], rad_prev[i][2*MAG_W-1 -: 2]};
         trial[i]  = {root_prev[i], 2'b01};
         rad_in[i] = {rad_prev[i][2*MAG_W-3:0], 2'b00};
         if (rem_sh[i] >= trial[i]) begin
            rem_in[i]  = rem_sh[i] - trial[i];
            root_in[i] = {root_prev[i][MAG_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = rem_sh[i];
            root_in[i] = {root_prev[i][MAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SQRT_STAGES; i++) begin
         rad_ff[i]  <= rad_in[i];
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

### rtl/core/dcr_div.sv
module dcr_div #(
   parameter int DEN_W = 32,
   parameter int Q_W   = 31
) (
   input  logic             clock,
   input  logic [DEN_W-1:0] rem_init,
   input  logic [Q_W-1:0]   num_low,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quot
);

   logic [DEN_W-1:0] rem_ff   [Q_W];
   logic [DEN_W-1:0] den_ff   [Q_W];
   logic [Q_W-1:0]   low_ff   [Q_W];
   logic [Q_W-1:0]   q_ff     [Q_W];
   logic [DEN_W-1:0] rem_in   [Q_W];
   logic [Q_W-1:0]   low_in   [Q_W];
   logic [Q_W-1:0]   q_in     [Q_W];
   logic [DEN_W-1:0] rem_prev [Q_W];
   logic [DEN_W-1:0] den_prev [Q_W];
   logic [Q_W-1:0]   low_prev [Q_W];
   logic [Q_W-1:0]   q_prev   [Q_W];
   logic [DEN_W:0]   rem_sh   [Q_W];
   logic [DEN_W:0]   rem_sub  [Q_W];

   always_comb begin
      rem_prev[0] = rem_init;
      den_prev[0] = den;
      low_prev[0] = num_low;
      q_prev[0]   = '0;
      for (int i = 1; i < Q_W; i++) begin
         rem_prev[i] = rem_ff[i-1];
         den_prev[i] = den_ff[i-1];
         low_prev[i] = low_ff[i-1];
         q_prev[i]   = q_ff[i-1];
      end
      for (int i = 0; i < Q_W; i++) begin
         rem_sh[i]  = {rem_prev[i], low_prev[i][Q_W-1]};
         rem_sub[i] = rem_sh[i] - {1'b0, den_prev[i]};
         low_in[i]  = {low_prev[i][Q_W-2:0], 1'b0};
         if (rem_sh[i] >= {1'b0, den_prev[i]}) begin
            rem_in[i] = rem_sub[i][DEN_W-1:0];
            q_in[i]   = {q_prev[i][Q_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_sh[i][DEN_W-1:0];
            q_in[i]   = {q_prev[i][Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Q_W; i++) begin
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_prev[i];
         low_ff[i] <= low_in[i];
         q_ff[i]   <= q_in[i];
      end
   end

   assign quot = q_ff[Q_W-1];

endmodule

### rtl/core/dcr_resp.sv
module dcr_resp
   import dcr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  resp_in_type  resp_in,
   output resp_out_type resp_out
);

   localparam int NRM_W  = NRM_Q_W + 1;
   localparam int PRD_W  = NRM_W + VEL_W;
   localparam int DOT_W  = PRD_W + 1;
   localparam int DIFF_W = PROJ_W + 1;
   localparam int DLO_W  = 17;
   localparam int DHI_W  = DIFF_W - DLO_W;
   localparam int RP_W   = RATIO_W + 1 + DHI_W;
   localparam int FULL_W = RP_W + DLO_W;
   localparam int PE_W   = PROJ_W + ELAS_W + 1;
   localparam int CLO_W  = 21;
   localparam int CP_W   = NRM_W + CLO_W + 1;
   localparam int CN_W   = CP_W + CLO_W;
   localparam int DLT_W  = CN_W - NRM_FRAC;
   localparam int SUM_W  = DLT_W + 1;

   // stage valids
   logic [6:0] vld_ff;

   // r0: signed normal, ratios
   side_type                  r0_side_ff;
   logic signed [NRM_W-1:0]   r0_nx_ff, r0_ny_ff, r0_nx_in, r0_ny_in;
   logic [RATIO_W-1:0]        r0_r1_ff, r0_r2_ff;
   logic [NRM_W-1:0]          qx_ext, qy_ext;

   // r1: products of normal and velocity components
   side_type                  r1_side_ff;
   logic signed [NRM_W-1:0]   r1_nx_ff, r1_ny_ff;
   logic [RATIO_W-1:0]        r1_r1_ff, r1_r2_ff;
   logic signed [PRD_W-1:0]   r1_p_ff [4];
   logic signed [PRD_W-1:0]   r1_p_in [4];

   // r2: projections
   side_type                  r2_side_ff;
   logic signed [NRM_W-1:0]   r2_nx_ff, r2_ny_ff;
   logic [RATIO_W-1:0]        r2_r1_ff, r2_r2_ff;
   logic signed [PROJ_W-1:0]  r2_p1_ff, r2_p2_ff, r2_p1_in, r2_p2_in;
   logic signed [DOT_W-1:0]   dot1, dot2;

   // r3: partial products
   side_type                  r3_side_ff;
   logic signed [NRM_W-1:0]   r3_nx_ff, r3_ny_ff;
   logic signed [RP_W-1:0]    r3_a_lo_ff, r3_a_hi_ff, r3_b_lo_ff, r3_b_hi_ff;
   logic signed [RP_W-1:0]    r3_a_lo_in, r3_a_hi_in, r3_b_lo_in, r3_b_hi_in;
   logic signed [PE_W-1:0]    r3_pe_ff, r3_pe_in;
   logic signed [PROJ_W-1:0]  r3_bp_ff, r3_bp_in;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [RATIO_W:0]   r1_s, r2_s;
   logic [ELAS_W-1:0]         be;

   // r4: velocity changes
   side_type                  r4_side_ff;
   logic signed [NRM_W-1:0]   r4_nx_ff, r4_ny_ff;
   logic signed [CHG_W-1:0]   r4_c1_ff, r4_c2_ff, r4_c1_in, r4_c2_in;
   logic signed [FULL_W-1:0]  full_a, full_b;
   logic signed [CHG_W-1:0]   c1_el, c2_el, c_bn;

   // r5: change times normal, split
   side_type                  r5_side_ff;
   logic signed [CP_W-1:0]    r5_lo_ff [4];
   logic signed [CP_W-1:0]    r5_hi_ff [4];
   logic signed [CP_W-1:0]    r5_lo_in [4];
   logic signed [CP_W-1:0]    r5_hi_in [4];
   logic signed [CHG_W-1:0]   cc [4];
   logic signed [NRM_W-1:0]   nn [4];

   // r6: deltas
   side_type                  r6_side_ff;
   logic signed [DLT_W-1:0]   r6_d_ff [4];
   logic signed [DLT_W-1:0]   r6_d_in [4];
   logic signed [CN_W-1:0]    full_c [4];

   // r7: saturate
   logic                      out_vld_ff;
   logic                      out_hit_ff;
   logic [3:0][VEL_W-1:0]     out_vel_ff;
   logic [3:0][VEL_W-1:0]     vel_in;
   logic signed [VEL_W-1:0]   vv [4];
   logic signed [SUM_W-1:0]   vsum [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[5:0], resp_in.vld};
         out_vld_ff <= vld_ff[6];
      end
   end

   always_comb begin
      qx_ext   = {1'b0, resp_in.qx};
      qy_ext   = {1'b0, resp_in.qy};
      r0_nx_in = resp_in.side.neg_x ? $signed(-qx_ext) : $signed(qx_ext);
      r0_ny_in = resp_in.side.neg_y ? $signed(-qy_ext) : $signed(qy_ext);
   end

   always_ff @(posedge clock) begin
      r0_side_ff <= resp_in.side;
      r0_nx_ff   <= r0_nx_in;
      r0_ny_ff   <= r0_ny_in;
      r0_r1_ff   <= resp_in.side.msum_zero ? RATIO_ONE : resp_in.ratio.r1;
      r0_r2_ff   <= resp_in.side.msum_zero ? RATIO_ONE : resp_in.ratio.r2;
   end

   always_comb begin
      r1_p_in[0] = r0_nx_ff * r0_side_ff.v1x;
      r1_p_in[1] = r0_ny_ff * r0_side_ff.v1y;
      r1_p_in[2] = r0_nx_ff * r0_side_ff.v2x;
      r1_p_in[3] = r0_ny_ff * r0_side_ff.v2y;
   end

   always_ff @(posedge clock) begin
      r1_side_ff <= r0_side_ff;
      r1_nx_ff   <= r0_nx_ff;
      r1_ny_ff   <= r0_ny_ff;
      r1_r1_ff   <= r0_r1_ff;
      r1_r2_ff   <= r0_r2_ff;
      for (int i = 0; i < 4; i++) begin
         r1_p_ff[i] <= r1_p_in[i];
      end
   end

   always_comb begin
      dot1     = DOT_W'(r1_p_ff[0]) + DOT_W'(r1_p_ff[1]);
      dot2     = DOT_W'(r1_p_ff[2]) + DOT_W'(r1_p_ff[3]);
      r2_p1_in = dot1[NRM_FRAC +: PROJ_W];
      r2_p2_in = dot2[NRM_FRAC +: PROJ_W];
   end

   always_ff @(posedge clock) begin
      r2_side_ff <= r1_side_ff;
      r2_nx_ff   <= r1_nx_ff;
      r2_ny_ff   <= r1_ny_ff;
      r2_r1_ff   <= r1_r1_ff;
      r2_r2_ff   <= r1_r2_ff;
      r2_p1_ff   <= r2_p1_in;
      r2_p2_ff   <= r2_p2_in;
   end

   always_comb begin
      diff       = DIFF_W'(r2_p2_ff) - DIFF_W'(r2_p1_ff);
      r1_s       = $signed({1'b0, r2_r1_ff});
      r2_s       = $signed({1'b0, r2_r2_ff});
      r3_a_lo_in = r1_s * $signed({1'b0, diff[DLO_W-1:0]});
      r3_a_hi_in = r1_s * $signed(diff[DIFF_W-1:DLO_W]);
      r3_b_lo_in = r2_s * $signed({1'b0, diff[DLO_W-1:0]});
      r3_b_hi_in = r2_s * $signed(diff[DIFF_W-1:DLO_W]);
      r3_bp_in   = r2_side_ff.first_mov ? r2_p1_ff : r2_p2_ff;
      be         = r2_side_ff.first_mov ? r2_side_ff.e1 : r2_side_ff.e2;
      r3_pe_in   = r3_bp_in * $signed({1'b0, be});
   end

   always_ff @(posedge clock) begin
      r3_side_ff <= r2_side_ff;
      r3_nx_ff   <= r2_nx_ff;
      r3_ny_ff   <= r2_ny_ff;
      r3_a_lo_ff <= r3_a_lo_in;
      r3_a_hi_ff <= r3_a_hi_in;
      r3_b_lo_ff <= r3_b_lo_in;
      r3_b_hi_ff <= r3_b_hi_in;
      r3_pe_ff   <= r3_pe_in;
      r3_bp_ff   <= r3_bp_in;
   end

   always_comb begin
      full_a = (FULL_W'(r3_a_hi_ff) <<< DLO_W) + FULL_W'(r3_a_lo_ff);
      full_b = -((FULL_W'(r3_b_hi_ff) <<< DLO_W) + FULL_W'(r3_b_lo_ff));
      c1_el  = CHG_W'($signed(full_a[FULL_W-1:RATIO_FRAC]));
      c2_el  = CHG_W'($signed(full_b[FULL_W-1:RATIO_FRAC]));
      c_bn   = -(CHG_W'(r3_bp_ff) + CHG_W'(r3_pe_ff >>> ELAS_FRAC));
      if (!r3_side_ff.first_mov) begin
         r4_c1_in = '0;
         r4_c2_in = c_bn;
      end else if (!r3_side_ff.second_mov) begin
         r4_c1_in = c_bn;
         r4_c2_in = '0;
      end else begin
         r4_c1_in = c1_el;
         r4_c2_in = c2_el;
      end
   end

   always_ff @(posedge clock) begin
      r4_side_ff <= r3_side_ff;
      r4_nx_ff   <= r3_nx_ff;
      r4_ny_ff   <= r3_ny_ff;
      r4_c1_ff   <= r4_c1_in;
      r4_c2_ff   <= r4_c2_in;
   end

   always_comb begin
      cc[0] = r4_c1_ff;
      cc[1] = r4_c1_ff;
      cc[2] = r4_c2_ff;
      cc[3] = r4_c2_ff;
      nn[0] = r4_nx_ff;
      nn[1] = r4_ny_ff;
      nn[2] = r4_nx_ff;
      nn[3] = r4_ny_ff;
      for (int i = 0; i < 4; i++) begin
         r5_lo_in[i] = nn[i] * $signed({1'b0, cc[i][CLO_W-1:0]});
         r5_hi_in[i] = nn[i] * $signed(cc[i][CHG_W-1:CLO_W]);
      end
   end

   always_ff @(posedge clock) begin
      r5_side_ff <= r4_side_ff;
      for (int i = 0; i < 4; i++) begin
         r5_lo_ff[i] <= r5_lo_in[i];
         r5_hi_ff[i] <= r5_hi_in[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         full_c[i]  = (CN_W'(r5_hi_ff[i]) <<< CLO_W) + CN_W'(r5_lo_ff[i]);
         r6_d_in[i] = full_c[i][CN_W-1:NRM_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      r6_side_ff <= r5_side_ff;
      for (int i = 0; i < 4; i++) begin
         r6_d_ff[i] <= r6_d_in[i];
      end
   end

   always_comb begin
      vv[0] = r6_side_ff.v1x;
      vv[1] = r6_side_ff.v1y;
      vv[2] = r6_side_ff.v2x;
      vv[3] = r6_side_ff.v2y;
      for (int i = 0; i < 4; i++) begin
         vsum[i] = SUM_W'(vv[i]) + SUM_W'(r6_d_ff[i]);
         if (!r6_side_ff.go) begin
            vel_in[i] = vv[i];
         end else if (vsum[i][SUM_W-1:VEL_W-1] != {(SUM_W-VEL_W+1){vsum[i][SUM_W-1]}}) begin
            vel_in[i] = vsum[i][SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                         : {1'b0, {(VEL_W-1){1'b1}}};
         end else begin
            vel_in[i] = vsum[i][VEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_hit_ff <= r6_side_ff.go;
      out_vel_ff <= vel_in;
   end

   assign resp_out = {out_vld_ff, out_hit_ff, out_vel_ff};

endmodule

### rtl/core/disk_collision_response_top.sv
// Channel   Handshake             Ports
// request   start & !busy         req_delta_x .. req_flags
// response  rsp_valid, one cycle  rsp_hit, rsp_new_first_vel_x .. rsp_new_second_vel_y
//
// One transaction per cycle; busy is always low.
// rsp_valid is raised once the request has passed s0 to s2, the 32-stage square root,
// the 31-stage normal divider and the response stages r0 to r7.
// Synchronous reset clears the valid bits only; no transaction survives it.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module disk_collision_response_top
   import dcr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [VEL_W-1:0]  req_delta_x,
   input  logic signed [VEL_W-1:0]  req_delta_y,
   input  logic signed [VEL_W-1:0]  req_first_vel_x,
   input  logic signed [VEL_W-1:0]  req_first_vel_y,
   input  logic signed [VEL_W-1:0]  req_second_vel_x,
   input  logic signed [VEL_W-1:0]  req_second_vel_y,
   input  logic [MASS_W-1:0]        req_first_mass,
   input  logic [MASS_W-1:0]        req_second_mass,
   input  logic [MASS_W-1:0]        req_radius_sum,
   input  logic [ELAS_W-1:0]        req_first_elasticity,
   input  logic [ELAS_W-1:0]        req_second_elasticity,
   input  logic [FLAG_W-1:0]        req_flags,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic signed [VEL_W-1:0]  rsp_new_first_vel_x,
   output logic signed [VEL_W-1:0]  rsp_new_first_vel_y,
   output logic signed [VEL_W-1:0]  rsp_new_second_vel_x,
   output logic signed [VEL_W-1:0]  rsp_new_second_vel_y
);

   logic                   s0_vld_ff, s1_vld_ff, s2_vld_ff;
   logic [FRONT_LAT-1:0]   vld_pipe_ff;

   logic [VEL_W-1:0]       s0_ax_ff, s0_ay_ff, s0_ax_in, s0_ay_in;
   logic [MASS_W-1:0]      s0_rs_ff, s0_m1_ff, s0_m2_ff;
   logic                   s0_shit_ff;
   side_type               s0_side_ff, s0_side_in;

   logic [2*VEL_W-1:0]     s1_dxdx_ff, s1_dydy_ff, s1_rsrs_ff;
   logic [VEL_W-1:0]       s1_ax_ff, s1_ay_ff;
   logic [MASS_W-1:0]      s1_m1_ff, s1_m2_ff;
   logic                   s1_shit_ff;
   side_type               s1_side_ff;

   logic [2*VEL_W-1:0]     s2_d2_ff, s2_d2_in;
   logic [VEL_W-1:0]       s2_ax_ff, s2_ay_ff;
   logic [MASS_W-1:0]      s2_m1_ff, s2_m2_ff;
   logic [MSUM_W-1:0]      s2_msum_ff, s2_msum_in;
   side_type               s2_side_ff, s2_side_in;

   logic [MAG_W-1:0]       mag;
   logic [2*VEL_W-1:0]     abs_dly;
   logic [NRM_Q_W-1:0]     qx, qy;
   ratio_type              ratio_raw, ratio_dly;
   side_type               side_dly;
   resp_in_type            resp_in;
   resp_out_type           resp_out;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff   <= 1'b0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         vld_pipe_ff <= '0;
      end else begin
         s0_vld_ff   <= start & ~busy;
         s1_vld_ff   <= s0_vld_ff;
         s2_vld_ff   <= s1_vld_ff;
         vld_pipe_ff <= {vld_pipe_ff[FRONT_LAT-2:0], s2_vld_ff};
      end
   end

   always_comb begin
      s0_ax_in              = req_delta_x[VEL_W-1] ? VEL_W'(-req_delta_x) : req_delta_x;
      s0_ay_in              = req_delta_y[VEL_W-1] ? VEL_W'(-req_delta_y) : req_delta_y;
      s0_side_in.v1x        = req_first_vel_x;
      s0_side_in.v1y        = req_first_vel_y;
      s0_side_in.v2x        = req_second_vel_x;
      s0_side_in.v2y        = req_second_vel_y;
      s0_side_in.e1         = req_first_elasticity;
      s0_side_in.e2         = req_second_elasticity;
      s0_side_in.first_mov  = req_flags[FLAG_FIRST_MOV];
      s0_side_in.second_mov = req_flags[FLAG_SECOND_MOV];
      s0_side_in.neg_x      = req_delta_x[VEL_W-1];
      s0_side_in.neg_y      = req_delta_y[VEL_W-1];
      s0_side_in.go         = 1'b0;
      s0_side_in.msum_zero  = 1'b0;
   end

   always_ff @(posedge clock) begin
      s0_ax_ff   <= s0_ax_in;
      s0_ay_ff   <= s0_ay_in;
      s0_rs_ff   <= req_radius_sum;
      s0_m1_ff   <= req_first_mass;
      s0_m2_ff   <= req_second_mass;
      s0_shit_ff <= req_flags[FLAG_SECOND_HIT];
      s0_side_ff <= s0_side_in;
   end

   always_ff @(posedge clock) begin
      s1_dxdx_ff <= s0_ax_ff * s0_ax_ff;
      s1_dydy_ff <= s0_ay_ff * s0_ay_ff;
      s1_rsrs_ff <= s0_rs_ff * s0_rs_ff;
      s1_ax_ff   <= s0_ax_ff;
      s1_ay_ff   <= s0_ay_ff;
      s1_m1_ff   <= s0_m1_ff;
      s1_m2_ff   <= s0_m2_ff;
      s1_shit_ff <= s0_shit_ff;
      s1_side_ff <= s0_side_ff;
   end

   always_comb begin
      s2_d2_in             = s1_dxdx_ff + s1_dydy_ff;
      s2_msum_in           = {1'b0, s1_m1_ff} + {1'b0, s1_m2_ff};
      s2_side_in           = s1_side_ff;
      s2_side_in.go        = ~s1_shit_ff && (s2_d2_in != '0) && (s2_d2_in <= s1_rsrs_ff);
      s2_side_in.msum_zero = (s2_msum_in == '0);
   end

   always_ff @(posedge clock) begin
      s2_d2_ff   <= s2_d2_in;
      s2_msum_ff <= s2_msum_in;
      s2_ax_ff   <= s1_ax_ff;
      s2_ay_ff   <= s1_ay_ff;
      s2_m1_ff   <= s1_m1_ff;
      s2_m2_ff   <= s1_m2_ff;
      s2_side_ff <= s2_side_in;
   end

   dcr_isqrt u_isqrt (
      .clock    (clock),
      .radicand (s2_d2_ff),
      .root     (mag)
   );

   dcr_delay #(
      .WIDTH (2*VEL_W),
      .DEPTH (SQRT_STAGES)
   ) u_abs_dly (
      .clock (clock),
      .din   ({s2_ax_ff, s2_ay_ff}),
      .dout  (abs_dly)
   );

   // |d| * 2^30 / mag
   dcr_div #(
      .DEN_W (MAG_W),
      .Q_W   (NRM_Q_W)
   ) u_div_x (
      .clock    (clock),
      .rem_init ({1'b0, abs_dly[2*VEL_W-1:VEL_W+1]}),
      .num_low  ({abs_dly[VEL_W], {(NRM_Q_W-1){1'b0}}}),
      .den      (mag),
      .quot     (qx)
   );

   dcr_div #(
      .DEN_W (MAG_W),
      .Q_W   (NRM_Q_W)
   ) u_div_y (
      .clock    (clock),
      .rem_init ({1'b0, abs_dly[VEL_W-1:1]}),
      .num_low  ({abs_dly[0], {(NRM_Q_W-1){1'b0}}}),
      .den      (mag),
      .quot     (qy)
   );

   // 2 * m * 2^28 / (m1 + m2)
   dcr_div #(
      .DEN_W (MSUM_W),
      .Q_W   (RATIO_W)
   ) u_div_r1 (
      .clock    (clock),
      .rem_init ({2'b00, s2_m2_ff[MASS_W-1:1]}),
      .num_low  ({s2_m2_ff[0], {(RATIO_W-1){1'b0}}}),
      .den      (s2_msum_ff),
      .quot     (ratio_raw.r1)
   );

   dcr_div #(
      .DEN_W (MSUM_W),
      .Q_W   (RATIO_W)
   ) u_div_r2 (
      .clock    (clock),
      .rem_init ({2'b00, s2_m1_ff[MASS_W-1:1]}),
      .num_low  ({s2_m1_ff[0], {(RATIO_W-1){1'b0}}}),
      .den      (s2_msum_ff),
      .quot     (ratio_raw.r2)
   );

   dcr_delay #(
      .WIDTH ($bits(ratio_type)),
      .DEPTH (FRONT_LAT - MASS_DIV_STAGES)
   ) u_ratio_dly (
      .clock (clock),
      .din   (ratio_raw),
      .dout  (ratio_dly)
   );

   dcr_delay #(
      .WIDTH ($bits(side_type)),
      .DEPTH (FRONT_LAT)
   ) u_side_dly (
      .clock (clock),
      .din   (s2_side_ff),
      .dout  (side_dly)
   );

   always_comb begin
      resp_in.vld   = vld_pipe_ff[FRONT_LAT-1];
      resp_in.qx    = qx;
      resp_in.qy    = qy;
      resp_in.ratio = ratio_dly;
      resp_in.side  = side_dly;
   end

   dcr_resp u_resp (
      .clock    (clock),
      .reset    (reset),
      .resp_in  (resp_in),
      .resp_out (resp_out)
   );

   assign rsp_valid            = resp_out.vld;
   assign rsp_hit              = resp_out.hit;
   assign rsp_new_first_vel_x  = resp_out.vel[0];
   assign rsp_new_first_vel_y  = resp_out.vel[1];
   assign rsp_new_second_vel_x = resp_out.vel[2];
   assign rsp_new_second_vel_y = resp_out.vel[3];

endmodule

### bench/tb_disk_collision_response_top.sv
module tb_disk_collision_response_top;
   import dcr_pkg::*;

   typedef struct {
      logic signed [31:0] dx, dy, v1x, v1y, v2x, v2y;
      logic [31:0]        m1, m2, rs;
      logic [15:0]        e1, e2;
      logic [2:0]         fl;
   } pair_type;

   typedef struct {
      logic        hit;
      logic [31:0] vel [4];
   } velocity_out_type;

   localparam int LATENCY   = 73;
   localparam int CYCLE_CAP = 400000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [31:0] req_delta_x = 0, req_delta_y = 0;
   logic signed [31:0] req_first_vel_x = 0, req_first_vel_y = 0;
   logic signed [31:0] req_second_vel_x = 0, req_second_vel_y = 0;
   logic [31:0] req_first_mass = 0, req_second_mass = 0, req_radius_sum = 0;
   logic [15:0] req_first_elasticity = 0, req_second_elasticity = 0;
   logic [2:0]  req_flags = 0;
   logic rsp_valid, rsp_hit;
   logic signed [31:0] rsp_new_first_vel_x, rsp_new_first_vel_y;
   logic signed [31:0] rsp_new_second_vel_x, rsp_new_second_vel_y;

   velocity_out_type expected_velocities [$];
   int errors = 0;
   int cycles = 0;

   disk_collision_response_top uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic longint unsigned sqrt_floor(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) return 32'h7fffffff;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[31:0];
   endfunction

   function automatic longint along_normal(input longint c, input longint n);
      longint hi, lo;
      hi = c >>> 30;
      lo = c - (hi <<< 30);
      return hi * n + ((lo * n) >>> 30);
   endfunction

   function automatic longint normal_comp(input longint d, input longint unsigned mag);
      longint unsigned a;
      longint q;
      a = (d < 0) ? -d : d;
      q = longint'((a << 30) / mag);
      return (d < 0) ? -q : q;
   endfunction

   function automatic longint restitute(input longint p, input longint e);
      return -(p + ((p * e) >>> 8));
   endfunction

   function automatic velocity_out_type collide(input pair_type t);
      velocity_out_type r;
      longint dx, dy, v1x, v1y, v2x, v2y, nx, ny, p1, p2, c1, c2, r1, r2;
      longint unsigned d2, rr, mag, msum;
      dx = t.dx; dy = t.dy; v1x = t.v1x; v1y = t.v1y; v2x = t.v2x; v2y = t.v2y;
      d2 = longint'(dx * dx) + longint'(dy * dy);
      rr = longint'(t.rs) * longint'(t.rs);
      r.hit = 1'b0;
      r.vel[0] = t.v1x; r.vel[1] = t.v1y; r.vel[2] = t.v2x; r.vel[3] = t.v2y;
      if (!t.fl[FLAG_SECOND_HIT] && d2 != 0 && d2 <= rr) begin
         mag = sqrt_floor(d2);
         nx = normal_comp(dx, mag);
         ny = normal_comp(dy, mag);
         p1 = (nx * v1x + ny * v1y) >>> 30;
         p2 = (nx * v2x + ny * v2y) >>> 30;
         c1 = 0; c2 = 0;
         if (!t.fl[FLAG_FIRST_MOV]) begin
            c2 = restitute(p2, longint'(t.e2));
         end else if (!t.fl[FLAG_SECOND_MOV]) begin
            c1 = restitute(p1, longint'(t.e1));
         end else begin
            msum = longint'(t.m1) + longint'(t.m2);
            r1 = 64'sd1 << 28; r2 = 64'sd1 << 28;
            if (msum != 0) begin
               r1 = longint'(((2 * longint'(t.m2)) << 28) / msum);
               r2 = longint'(((2 * longint'(t.m1)) << 28) / msum);
            end
            c1 = (r1 * (p2 - p1)) >>> 28;
            c2 = (r2 * (p1 - p2)) >>> 28;
         end
         r.vel[0] = clamp32(v1x + along_normal(c1, nx));
         r.vel[1] = clamp32(v1y + along_normal(c1, ny));
         r.vel[2] = clamp32(v2x + along_normal(c2, nx));
         r.vel[3] = clamp32(v2y + along_normal(c2, ny));
         r.hit = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      velocity_out_type e;
      logic [31:0] got [4];
      if (!reset && rsp_valid) begin
         got[0] = rsp_new_first_vel_x; got[1] = rsp_new_first_vel_y;
         got[2] = rsp_new_second_vel_x; got[3] = rsp_new_second_vel_y;
         if (expected_velocities.size() == 0) begin
            report("response with no transaction outstanding");
         end else begin
            e = expected_velocities.pop_front();
            if (rsp_hit !== e.hit)
               report($sformatf("hit got %b exp %b", rsp_hit, e.hit));
            for (int i = 0; i < 4; i++)
               if (got[i] !== e.vel[i])
                  report($sformatf("vel[%0d] got %h exp %h", i, got[i], e.vel[i]));
         end
      end
   end

   task automatic send_pair(input pair_type t);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_delta_x <= t.dx; req_delta_y <= t.dy;
      req_first_vel_x <= t.v1x; req_first_vel_y <= t.v1y;
      req_second_vel_x <= t.v2x; req_second_vel_y <= t.v2y;
      req_first_mass <= t.m1; req_second_mass <= t.m2; req_radius_sum <= t.rs;
      req_first_elasticity <= t.e1; req_second_elasticity <= t.e2;
      req_flags <= t.fl;
      do @(posedge clock); while (busy);
      expected_velocities.push_back(collide(t));
   endtask

   function automatic logic [31:0] rand_scaled();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic logic signed [31:0] rand_vel();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return $signed($urandom) >>> $urandom_range(4, 31);
      endcase
   endfunction

   function automatic pair_type noise_pair();
      pair_type t;
      t.dx = $urandom; t.dy = $urandom; t.v1x = $urandom; t.v1y = $urandom;
      t.v2x = $urandom; t.v2y = $urandom; t.m1 = $urandom; t.m2 = $urandom;
      t.rs = $urandom; t.e1 = 16'($urandom); t.e2 = 16'($urandom);
      t.fl = 3'($urandom);
      return t;
   endfunction

   function automatic pair_type contact_pair();
      pair_type t;
      longint lim;
      t = noise_pair();
      t.rs = $urandom >> $urandom_range(0, 30);
      lim = longint'(t.rs) >> 2;
      t.dx = 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
      t.dy = 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
      if ($urandom_range(0, 15) == 0 && t.rs < 32'h80000000) begin
         t.dx = $urandom_range(0, 1) ? t.rs : -t.rs;
         t.dy = 0;
      end
      t.v1x = rand_vel(); t.v1y = rand_vel(); t.v2x = rand_vel(); t.v2y = rand_vel();
      t.m1 = rand_scaled(); t.m2 = rand_scaled();
      if ($urandom_range(0, 30) == 0) t.m1 = 0;
      if ($urandom_range(0, 30) == 0) t.m2 = 0;
      t.e1 = 16'($urandom >> $urandom_range(0, 15));
      t.e2 = 16'($urandom >> $urandom_range(0, 15));
      t.fl = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0) t.fl[FLAG_SECOND_HIT] = 1'b0;
      return t;
   endfunction

   task automatic test_pass_through();
      pair_type t;
      t = contact_pair();
      t.dx = 32'sh00010000; t.dy = 0; t.rs = 32'h00020000; t.fl = 3'b111;
      send_pair(t);
      t.fl = 3'b011; t.rs = 32'h0000ffff;
      send_pair(t);
      t.dx = 0; t.dy = 0; t.rs = 32'hffffffff;
      send_pair(t);
      t.dx = 32'sh7fffffff; t.dy = 32'sh80000000; t.rs = 32'hffffffff;
      send_pair(t);
   endtask

   task automatic test_modes();
      pair_type t;
      for (int f = 0; f < 8; f++) begin
         t = contact_pair();
         t.dx = 32'sh00010000; t.dy = -32'sh00008000; t.rs = 32'h00030000;
         t.fl = 3'(f);
         send_pair(t);
      end
   endtask

   task automatic test_extremes();
      pair_type t;
      t = contact_pair();
      t.dx = 32'sh40000000; t.dy = -32'sh40000000; t.rs = 32'hffffffff; t.fl = 3'b011;
      t.v1x = 32'sh7fffffff; t.v1y = 32'sh80000000;
      t.v2x = 32'sh80000000; t.v2y = 32'sh7fffffff;
      t.m1 = 32'hffffffff; t.m2 = 1; t.e1 = 16'hffff; t.e2 = 16'hffff;
      send_pair(t);
      t.m1 = 0; t.m2 = 0;
      send_pair(t);
      t.m1 = 1; t.m2 = 32'hffffffff; t.fl = 3'b001;
      send_pair(t);
      t.fl = 3'b010; t.e1 = 0; t.e2 = 0;
      send_pair(t);
      t.dx = 1; t.dy = 0; t.rs = 1; t.fl = 3'b011; t.v1x = 0; t.v2x = 0;
      send_pair(t);
      t.dx = 32'sh80000000; t.dy = 32'sh80000000; t.rs = 32'hffffffff;
      send_pair(t);
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++)
         send_pair(($urandom_range(0, 4) == 0) ? noise_pair() : contact_pair());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pass_through();
      test_modes();
      test_extremes();
      test_random(2000);
      start <= 1'b0;
      while (expected_velocities.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
rtl/core/dcr_pkg.sv
rtl/core/dcr_delay.sv
rtl/core/dcr_isqrt.sv
rtl/core/dcr_div.sv
rtl/core/dcr_resp.sv
rtl/core/disk_collision_response_top.sv
bench/tb_disk_collision_response_top.sv
